FILE: sv/bcs_pkg.sv
// Shared types and constants of the banded Cholesky solver.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package bcs_pkg;

    localparam int MAX_SIZE    = 256;
    localparam int MAX_BAND    = 16;
    localparam int MAX_RHS     = 4;
    localparam int VALUE_WIDTH = 32;

    localparam int BAND_DEPTH   = MAX_SIZE * MAX_BAND;
    localparam int CORNER_DEPTH = MAX_BAND * MAX_SIZE;
    localparam int RHS_DEPTH    = MAX_SIZE * MAX_RHS;

    localparam logic [1:0] REG_SYSTEM_SIZE = 2'd0;
    localparam logic [1:0] REG_BAND_WIDTH  = 2'd1;
    localparam logic [1:0] REG_CORNER_ROWS = 2'd2;
    localparam logic [1:0] REG_RHS_COUNT   = 2'd3;

    typedef enum logic [2:0] {
        REQ_BAND   = 3'd0,
        REQ_CORNER = 3'd1,
        REQ_RHS    = 3'd2,
        REQ_START  = 3'd3,
        REQ_SOLVE  = 3'd4,
        REQ_READ   = 3'd5
    } req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_ROW,
        ST_F_RFN_WAIT,
        ST_F_BAND,
        ST_F_CORNER,
        ST_MAC_RD,
        ST_MAC_MUL,
        ST_MAC_ADD,
        ST_DIAG_RD,
        ST_DIAG_CHK,
        ST_FIN_RD,
        ST_FIN_DIFF,
        ST_FIN_DIVGO,
        ST_FIN_DIV,
        ST_B_ROW,
        ST_B_SRCH_RD,
        ST_B_SRCH_CHK,
        ST_B_CORNER,
        ST_B_BAND
    } state_t;

    typedef struct packed {
        logic [8:0] system_size;
        logic [4:0] band_width;
        logic [4:0] corner_rows;
        logic [2:0] rhs_count;
    } cfg_t;

    typedef struct packed {
        logic        coef_re;
        logic        coef_corner;
        logic [11:0] coef_addr;
        logic        rfn_re;
        logic [7:0]  rfn_addr;
        logic        rhs_re;
        logic        rhs_we;
        logic [9:0]  rhs_addr;
        logic        clear_sums;
        logic        mul_en;
        logic        acc_en;
        logic        diag_ld;
        logic        diff_ld;
        logic [1:0]  sum_sel;
        logic        div_start;
    } cmd_t;

    typedef struct packed {
        logic       diag_zero;
        logic       div_done;
        logic [3:0] rfn_q;
    } stat_t;

endpackage
`default_nettype wire

FILE: sv/bcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: sv/bcs_div.sv
// Radix-2 restoring divider, 64-bit signed dividend by 32-bit signed divisor,
// one quotient bit per cycle, quotient truncated and saturated to 32 bits.
`default_nettype none
module bcs_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [32:0] shifted;
    logic [32:0] trial;
    logic        too_big_neg;
    logic        too_big_pos;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            quo_next  = dividend[63] ? (64'd0 - dividend) : dividend;
            den_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[63] ^ divisor[31];
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // saturate the magnitude quotient to the signed result range
    assign too_big_neg = (|quo_reg[63:32]) || (quo_reg[31] && (|quo_reg[30:0]));
    assign too_big_pos = (|quo_reg[63:32]) || quo_reg[31];

    always_comb
    begin
        if (neg_reg)
        begin
            quotient = too_big_neg ? 32'h8000_0000 : (32'd0 - quo_reg[31:0]);
        end
        else
        begin
            quotient = too_big_pos ? 32'h7FFF_FFFF : quo_reg[31:0];
        end
    end

    assign done = done_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

FILE: sv/bcs_datapath.sv
// Datapath: factor, corner, start-pointer and solution memories, the
// multiply-accumulate unit, the row finish logic and the divider.
// Depends on bcs_pkg, bcs_ram and bcs_div.
`default_nettype none
module bcs_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [2:0]    req_type,
    input  wire logic [7:0]    row,
    input  wire logic [7:0]    column,
    input  wire logic [1:0]    component,
    input  wire logic [31:0]   data_value,
    input  wire bcs_pkg::cmd_t cmd,
    output bcs_pkg::stat_t     stat,
    output logic [31:0]        read_value
);

    localparam logic [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            s = a[63] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
        begin
            s = a[63] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

    logic        host_band_we, host_corner_we, host_rhs_we, host_rfn_we, host_read;
    logic [31:0] band_q, corner_q, rhs_q, coef_q;
    logic [3:0]  rfn_q;
    logic        rhs_we;
    logic [9:0]  rhs_waddr, rhs_raddr;
    logic [31:0] rhs_wdata;
    logic        rhs_re;
    logic        coef_corner_reg;
    logic        rd_pend_reg;
    logic [63:0] product_reg;
    logic [63:0] sums_reg [bcs_pkg::MAX_RHS];
    logic [31:0] diag_reg;
    logic [63:0] diff_reg;
    logic [63:0] scaled;
    logic        div_done;
    logic [31:0] div_quo;

    assign host_band_we   = accept && (req_type == bcs_pkg::REQ_BAND) && (column[7:4] == 4'd0);
    assign host_corner_we = accept && (req_type == bcs_pkg::REQ_CORNER) && (row[7:4] == 4'd0);
    assign host_rhs_we    = accept && (req_type == bcs_pkg::REQ_RHS);
    assign host_rfn_we    = accept && (req_type == bcs_pkg::REQ_START);
    assign host_read      = accept && (req_type == bcs_pkg::REQ_READ);

    bcs_ram #(.WIDTH(32), .DEPTH(bcs_pkg::BAND_DEPTH)) u_band (
        .clk   (clk),
        .we    (host_band_we),
        .waddr ({row, column[3:0]}),
        .wdata (data_value),
        .re    (cmd.coef_re && !cmd.coef_corner),
        .raddr (cmd.coef_addr),
        .rdata (band_q)
    );

    bcs_ram #(.WIDTH(32), .DEPTH(bcs_pkg::CORNER_DEPTH)) u_corner (
        .clk   (clk),
        .we    (host_corner_we),
        .waddr ({row[3:0], column}),
        .wdata (data_value),
        .re    (cmd.coef_re && cmd.coef_corner),
        .raddr (cmd.coef_addr),
        .rdata (corner_q)
    );

    bcs_ram #(.WIDTH(4), .DEPTH(bcs_pkg::MAX_SIZE)) u_rfn (
        .clk   (clk),
        .we    (host_rfn_we),
        .waddr (row),
        .wdata (data_value[3:0]),
        .re    (cmd.rfn_re),
        .raddr (cmd.rfn_addr),
        .rdata (rfn_q)
    );

    // host writes only while idle, solver writes only while busy
    assign rhs_we    = host_rhs_we || cmd.rhs_we;
    assign rhs_waddr = host_rhs_we ? {row, component} : cmd.rhs_addr;
    assign rhs_wdata = host_rhs_we ? data_value : div_quo;
    assign rhs_re    = cmd.rhs_re || host_read;
    assign rhs_raddr = cmd.rhs_re ? cmd.rhs_addr : {row, component};

    bcs_ram #(.WIDTH(32), .DEPTH(bcs_pkg::RHS_DEPTH)) u_rhs (
        .clk   (clk),
        .we    (rhs_we),
        .waddr (rhs_waddr),
        .wdata (rhs_wdata),
        .re    (rhs_re),
        .raddr (rhs_raddr),
        .rdata (rhs_q)
    );

    assign coef_q = coef_corner_reg ? corner_q : band_q;
    assign scaled = {{16{rhs_q[31]}}, rhs_q, 16'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            for (int r = 0; r < bcs_pkg::MAX_RHS; r++)
            begin
                sums_reg[r] <= '0;
            end
        end
        else
        begin
            rd_pend_reg <= host_read;
            if (cmd.clear_sums)
            begin
                for (int r = 0; r < bcs_pkg::MAX_RHS; r++)
                begin
                    sums_reg[r] <= '0;
                end
            end
            else if (cmd.acc_en)
            begin
                sums_reg[cmd.sum_sel] <= sat_add(sums_reg[cmd.sum_sel], product_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_re)
        begin
            coef_corner_reg <= cmd.coef_corner;
        end
        if (cmd.mul_en)
        begin
            product_reg <= 64'($signed(coef_q) * $signed(rhs_q));
        end
        if (cmd.diag_ld)
        begin
            diag_reg <= coef_q;
        end
        if (cmd.diff_ld)
        begin
            diff_reg <= sat_sub(scaled, sums_reg[cmd.sum_sel]);
        end
    end

    bcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (diff_reg),
        .divisor  (diag_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign stat.diag_zero = (coef_q == 32'd0);
    assign stat.div_done  = div_done;
    assign stat.rfn_q     = rfn_q;
    assign read_value     = rd_pend_reg ? rhs_q : 32'd0;

`ifndef ASSERT_OFF
    a_rhs_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(host_rhs_we && cmd.rhs_we))
        else $error("host and solver write the solution memory together");
`endif

endmodule
`default_nettype wire

FILE: sv/bcs_ctrl.sv
// Solve sequencer: forward pass, reach search and back pass over the band
// and corner rows, issuing commands to the datapath. Depends on bcs_pkg.
`default_nettype none
module bcs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [2:0]     req_type,
    input  wire bcs_pkg::cfg_t  cfg,
    input  wire bcs_pkg::stat_t stat,
    output bcs_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                done,
    output logic                status
);

    bcs_pkg::state_t state_reg, state_next;
    bcs_pkg::state_t ret_reg, ret_next;
    logic [7:0]  i_reg, i_next;
    logic [8:0]  j_reg, j_next;
    logic [7:0]  last_reg, last_next;
    logic [4:0]  cr_reg, cr_next;
    logic [1:0]  r_reg, r_next;
    logic        back_reg, back_next;
    logic [11:0] caddr_reg, caddr_next;
    logic        ccorner_reg, ccorner_next;
    logic [7:0]  xrow_reg, xrow_next;
    logic        done_reg, done_next;
    logic        status_reg, status_next;

    logic [8:0] n_eff;
    logic [4:0] k_eff, k_m1, c_pre, c_eff;
    logic [2:0] m_eff;
    logic [8:0] bandn;
    logic [9:0] ij_sum;
    logic [8:0] dcr;
    logic [9:0] slot;
    logic [8:0] reach;
    logic       last_r;

    always_comb
    begin
        if (cfg.system_size == 9'd0)
            n_eff = 9'd1;
        else if (cfg.system_size > 9'(bcs_pkg::MAX_SIZE))
            n_eff = 9'(bcs_pkg::MAX_SIZE);
        else
            n_eff = cfg.system_size;
        if (cfg.band_width == 5'd0)
            k_eff = 5'd1;
        else if (cfg.band_width > 5'(bcs_pkg::MAX_BAND))
            k_eff = 5'(bcs_pkg::MAX_BAND);
        else
            k_eff = cfg.band_width;
        if (cfg.rhs_count == 3'd0)
            m_eff = 3'd1;
        else if (cfg.rhs_count > 3'(bcs_pkg::MAX_RHS))
            m_eff = 3'(bcs_pkg::MAX_RHS);
        else
            m_eff = cfg.rhs_count;
        c_pre = (cfg.corner_rows > k_eff) ? k_eff : cfg.corner_rows;
        c_eff = ({4'd0, c_pre} > n_eff) ? n_eff[4:0] : c_pre;
    end

    assign k_m1   = k_eff - 5'd1;
    assign bandn  = n_eff - {4'd0, c_eff};
    assign ij_sum = {2'd0, i_reg} + {1'b0, j_reg};
    assign dcr    = {1'b0, i_reg} - bandn;
    assign slot   = {5'd0, k_m1} + {2'd0, i_reg} - {1'b0, j_reg};
    assign reach  = {5'd0, stat.rfn_q} + {1'b0, last_reg} - {1'b0, i_reg};
    assign last_r = ({1'b0, r_reg} == (m_eff - 3'd1));

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        last_next    = last_reg;
        cr_next      = cr_reg;
        r_next       = r_reg;
        back_next    = back_reg;
        caddr_next   = caddr_reg;
        ccorner_next = ccorner_reg;
        xrow_next    = xrow_reg;
        done_next    = 1'b0;
        status_next  = 1'b0;
        cmd          = '0;

        unique case (state_reg)
            bcs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == bcs_pkg::REQ_SOLVE)
                    begin
                        i_next     = '0;
                        r_next     = '0;
                        back_next  = 1'b0;
                        state_next = bcs_pkg::ST_F_ROW;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end

            // forward pass: start a row
            bcs_pkg::ST_F_ROW:
            begin
                cmd.clear_sums = 1'b1;
                if ({1'b0, i_reg} < bandn)
                begin
                    cmd.rfn_re   = 1'b1;
                    cmd.rfn_addr = i_reg;
                    state_next   = bcs_pkg::ST_F_RFN_WAIT;
                end
                else
                begin
                    j_next     = '0;
                    cr_next    = dcr[4:0];
                    state_next = bcs_pkg::ST_F_CORNER;
                end
            end

            bcs_pkg::ST_F_RFN_WAIT:
            begin
                j_next     = {5'd0, stat.rfn_q};
                state_next = bcs_pkg::ST_F_BAND;
            end

            bcs_pkg::ST_F_BAND:
            begin
                if (j_reg < {4'd0, k_m1})
                begin
                    j_next = j_reg + 9'd1;
                    // skip slots left of column zero
                    if (ij_sum >= {5'd0, k_m1})
                    begin
                        caddr_next   = {i_reg, j_reg[3:0]};
                        ccorner_next = 1'b0;
                        xrow_next    = 8'(ij_sum - {5'd0, k_m1});
                        r_next       = '0;
                        ret_next     = bcs_pkg::ST_F_BAND;
                        state_next   = bcs_pkg::ST_MAC_RD;
                    end
                end
                else
                begin
                    state_next = bcs_pkg::ST_DIAG_RD;
                end
            end

            bcs_pkg::ST_F_CORNER:
            begin
                if (j_reg < {1'b0, i_reg})
                begin
                    caddr_next   = {cr_reg[3:0], j_reg[7:0]};
                    ccorner_next = 1'b1;
                    xrow_next    = j_reg[7:0];
                    j_next       = j_reg + 9'd1;
                    r_next       = '0;
                    ret_next     = bcs_pkg::ST_F_CORNER;
                    state_next   = bcs_pkg::ST_MAC_RD;
                end
                else
                begin
                    state_next = bcs_pkg::ST_DIAG_RD;
                end
            end

            // one term for every right-hand side
            bcs_pkg::ST_MAC_RD:
            begin
                cmd.coef_re     = 1'b1;
                cmd.coef_corner = ccorner_reg;
                cmd.coef_addr   = caddr_reg;
                cmd.rhs_re      = 1'b1;
                cmd.rhs_addr    = {xrow_reg, r_reg};
                state_next      = bcs_pkg::ST_MAC_MUL;
            end

            bcs_pkg::ST_MAC_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = bcs_pkg::ST_MAC_ADD;
            end

            bcs_pkg::ST_MAC_ADD:
            begin
                cmd.acc_en  = 1'b1;
                cmd.sum_sel = r_reg;
                if (last_r)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    r_next     = r_reg + 2'd1;
                    state_next = bcs_pkg::ST_MAC_RD;
                end
            end

            // row finish: fetch the diagonal, abort the solve if it is zero, else divide each right-hand side
            bcs_pkg::ST_DIAG_RD:
            begin
                cmd.coef_re = 1'b1;
                if ({1'b0, i_reg} >= bandn)
                begin
                    cmd.coef_corner = 1'b1;
                    cmd.coef_addr   = {dcr[3:0], i_reg};
                end
                else
                begin
                    cmd.coef_addr = {i_reg, k_m1[3:0]};
                end
                r_next     = '0;
                state_next = bcs_pkg::ST_DIAG_CHK;
            end

            bcs_pkg::ST_DIAG_CHK:
            begin
                if (stat.diag_zero)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b1;
                    state_next  = bcs_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.diag_ld = 1'b1;
                    state_next  = bcs_pkg::ST_FIN_RD;
                end
            end

            bcs_pkg::ST_FIN_RD:
            begin
                cmd.rhs_re   = 1'b1;
                cmd.rhs_addr = {i_reg, r_reg};
                state_next   = bcs_pkg::ST_FIN_DIFF;
            end

            bcs_pkg::ST_FIN_DIFF:
            begin
                cmd.diff_ld = 1'b1;
                cmd.sum_sel = r_reg;
                state_next  = bcs_pkg::ST_FIN_DIVGO;
            end

            bcs_pkg::ST_FIN_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = bcs_pkg::ST_FIN_DIV;
            end

            bcs_pkg::ST_FIN_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.rhs_we   = 1'b1;
                    cmd.rhs_addr = {i_reg, r_reg};
                    if (!last_r)
                    begin
                        r_next     = r_reg + 2'd1;
                        state_next = bcs_pkg::ST_FIN_RD;
                    end
                    else if (!back_reg)
                    begin
                        if ({1'b0, i_reg} == n_eff - 9'd1)
                        begin
                            back_next  = 1'b1;
                            last_next  = i_reg;
                            state_next = bcs_pkg::ST_B_ROW;
                        end
                        else
                        begin
                            i_next     = i_reg + 8'd1;
                            state_next = bcs_pkg::ST_F_ROW;
                        end
                    end
                    else if (i_reg == 8'd0)
                    begin
                        done_next  = 1'b1;
                        state_next = bcs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg - 8'd1;
                        state_next = bcs_pkg::ST_B_ROW;
                    end
                end
            end

            // back pass: clear sums, then pull in the last row reaching column i
            bcs_pkg::ST_B_ROW:
            begin
                cmd.clear_sums = 1'b1;
                j_next         = n_eff - 9'd1;
                cr_next        = c_eff - 5'd1;
                state_next     = bcs_pkg::ST_B_SRCH_RD;
            end

            bcs_pkg::ST_B_SRCH_RD:
            begin
                if (last_reg > i_reg)
                begin
                    cmd.rfn_re   = 1'b1;
                    cmd.rfn_addr = last_reg;
                    state_next   = bcs_pkg::ST_B_SRCH_CHK;
                end
                else
                begin
                    state_next = bcs_pkg::ST_B_CORNER;
                end
            end

            bcs_pkg::ST_B_SRCH_CHK:
            begin
                if (reach >= {4'd0, k_eff})
                begin
                    last_next  = last_reg - 8'd1;
                    state_next = bcs_pkg::ST_B_SRCH_RD;
                end
                else
                begin
                    state_next = bcs_pkg::ST_B_CORNER;
                end
            end

            bcs_pkg::ST_B_CORNER:
            begin
                if (j_reg > {1'b0, i_reg} && j_reg >= bandn)
                begin
                    caddr_next   = {cr_reg[3:0], i_reg};
                    ccorner_next = 1'b1;
                    xrow_next    = j_reg[7:0];
                    j_next       = j_reg - 9'd1;
                    cr_next      = cr_reg - 5'd1;
                    r_next       = '0;
                    ret_next     = bcs_pkg::ST_B_CORNER;
                    state_next   = bcs_pkg::ST_MAC_RD;
                end
                else
                begin
                    j_next     = {1'b0, i_reg} + 9'd1;
                    state_next = bcs_pkg::ST_B_BAND;
                end
            end

            bcs_pkg::ST_B_BAND:
            begin
                if (j_reg <= {1'b0, last_reg} && j_reg < bandn)
                begin
                    caddr_next   = {j_reg[7:0], slot[3:0]};
                    ccorner_next = 1'b0;
                    xrow_next    = j_reg[7:0];
                    j_next       = j_reg + 9'd1;
                    r_next       = '0;
                    ret_next     = bcs_pkg::ST_B_BAND;
                    state_next   = bcs_pkg::ST_MAC_RD;
                end
                else
                begin
                    state_next = bcs_pkg::ST_DIAG_RD;
                end
            end

            default:
            begin
                state_next = bcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bcs_pkg::ST_IDLE;
            ret_reg    <= bcs_pkg::ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            last_reg   <= '0;
            cr_reg     <= '0;
            r_reg      <= '0;
            back_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            last_reg   <= last_next;
            cr_reg     <= cr_next;
            r_reg      <= r_next;
            back_reg   <= back_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        caddr_reg   <= caddr_next;
        ccorner_reg <= ccorner_next;
        xrow_reg    <= xrow_next;
    end

    assign busy   = (state_reg != bcs_pkg::ST_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

`ifndef ASSERT_OFF
    a_rhs_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bcs_pkg::ST_IDLE) |-> ({1'b0, r_reg} < m_eff))
        else $error("right-hand side index beyond count");
    a_status_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg |-> done_reg)
        else $error("singular status without result strobe");
    a_abort_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcs_pkg::ST_DIAG_CHK && stat.diag_zero) |=> !busy)
        else $error("zero pivot did not end the solve");
`endif

endmodule
`default_nettype wire

FILE: sv/banded_cholesky_solve.sv
// Banded Cholesky solver. Load, row-start and read items: one item per cycle while
// no solve runs, result in the following cycle. Solve: forward plus back pass over
// n rows; per row, each band/corner term is multiplied and accumulated for every
// right-hand side, each then divided in the bit-serial divider; plus a reach search.
// Reset clears control and partial sums, presets configuration; factor and solution
// memories are undefined until written and get no clearing pass. No result stalls.
`default_nettype none
module banded_cholesky_solve (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item port
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  req_type,
    input  wire logic [7:0]  row,
    input  wire logic [7:0]  column,
    input  wire logic [1:0]  component,
    input  wire logic [31:0] data_value,
    // result port
    output logic             done,
    output logic             status,
    output logic [31:0]      read_value,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    bcs_pkg::cfg_t  cfg_reg;
    bcs_pkg::cmd_t  cmd;
    bcs_pkg::stat_t stat;
    logic           accept;
    logic           cfg_we;

    // an item enters whenever the sequencer is idle
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // configuration registers, to be written only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.system_size <= 9'(bcs_pkg::MAX_SIZE);
            cfg_reg.band_width  <= 5'd4;
            cfg_reg.corner_rows <= 5'd0;
            cfg_reg.rhs_count   <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                bcs_pkg::REG_SYSTEM_SIZE: cfg_reg.system_size <= pwdata[8:0];
                bcs_pkg::REG_BAND_WIDTH:  cfg_reg.band_width  <= pwdata[4:0];
                bcs_pkg::REG_CORNER_ROWS: cfg_reg.corner_rows <= pwdata[4:0];
                bcs_pkg::REG_RHS_COUNT:   cfg_reg.rhs_count   <= pwdata[2:0];
                default:                  cfg_reg.rhs_count   <= cfg_reg.rhs_count;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bcs_pkg::REG_SYSTEM_SIZE: prdata = {23'd0, cfg_reg.system_size};
            bcs_pkg::REG_BAND_WIDTH:  prdata = {27'd0, cfg_reg.band_width};
            bcs_pkg::REG_CORNER_ROWS: prdata = {27'd0, cfg_reg.corner_rows};
            bcs_pkg::REG_RHS_COUNT:   prdata = {29'd0, cfg_reg.rhs_count};
            default:                  prdata = 32'd0;
        endcase
    end

    // sequencer: walks rows, terms and right-hand sides
    bcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .cfg      (cfg_reg),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .status   (status)
    );

    // memories, multiply-accumulate and divider
    bcs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .row        (row),
        .column     (column),
        .component  (component),
        .data_value (data_value),
        .cmd        (cmd),
        .stat       (stat),
        .read_value (read_value)
    );

`ifndef ASSERT_OFF
    a_value_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (read_value != 32'd0) |-> done)
        else $error("read value shown without result strobe");
`endif

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for banded_cholesky_solve: loads factors, right-hand sides
// and row starts, runs solves and reads back the solution. Depends on bcs_pkg.
`timescale 1ns / 1ps
module testbench;

    localparam longint LMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint LMIN = -LMAX - 1;
    localparam longint QMAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint QMIN = -QMAX - 1;

    // One queued job: either an item for the command port or a register write.
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] wdata;
        logic [2:0]  raw_req;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [1:0]  comp;
        logic [31:0] data;
        int          gap;
    } job_t;

    typedef struct {
        logic        st;
        logic [31:0] val;
    } outcome_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic [2:0]  req_type = '0;
    logic [7:0]  row = '0;
    logic [7:0]  column = '0;
    logic [1:0]  component = '0;
    logic [31:0] data_value = '0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         busy;
    wire         done;
    wire         status;
    wire  [31:0] read_value;
    wire  [31:0] prdata;
    wire         pready;

    banded_cholesky_solve dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .req_type(req_type), .row(row), .column(column),
        .component(component), .data_value(data_value),
        .done(done), .status(status), .read_value(read_value),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    job_t     jobs[$];
    outcome_t awaited[$];
    int       errors = 0;

    // Shadow of the block: factor storage, in-place solution and raw registers.
    longint     band_coef[256][16];
    longint     corner_coef[16][256];
    longint     solution[256][4];
    logic [3:0] first_slot[256];
    longint     row_sums[4];
    logic [8:0] reg_size = 9'd256;
    logic [4:0] reg_band = 5'd4;
    logic [4:0] reg_corner = 5'd0;
    logic [2:0] reg_rhs = 3'd1;

    // Generator view: effective sizes and which entries have been written.
    int g_n, g_k, g_c, g_m;
    bit band_set[256][16];
    bit corner_set[16][256];
    bit rhs_set[256][4];
    bit start_set[256];
    bit gapped;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint add_sat(longint a, longint b);
        logic signed [64:0] s;
        s = a;
        s = s + b;
        if (s > LMAX) return LMAX;
        if (s < LMIN) return LMIN;
        return longint'(s);
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        logic signed [64:0] s;
        s = a;
        s = s - b;
        if (s > LMAX) return LMAX;
        if (s < LMIN) return LMIN;
        return longint'(s);
    endfunction

    function automatic longint mul_sat(longint a, longint b);
        logic signed [127:0] p;
        p = a;
        p = p * b;
        if (p > LMAX) return LMAX;
        if (p < LMIN) return LMIN;
        return longint'(p);
    endfunction

    function automatic void mac_column(longint coef, int col, int m);
        for (int r = 0; r < m; r++)
            row_sums[r] = add_sat(row_sums[r], mul_sat(coef, solution[col][r]));
    endfunction

    function automatic void clear_row_sums();
        for (int r = 0; r < 4; r++) row_sums[r] = 0;
    endfunction

    // Divide (b << 16) - sum by the diagonal, truncating, and clamp to Q16.16.
    function automatic void divide_row(int i, longint diag, int m);
        longint diff, q;
        for (int r = 0; r < m; r++)
        begin
            diff = sub_sat(mul_sat(solution[i][r], 65536), row_sums[r]);
            if (diag == -1 && diff == LMIN) q = LMAX;
            else q = diff / diag;
            if (q > QMAX) q = QMAX;
            if (q < QMIN) q = QMIN;
            solution[i][r] = q;
        end
    endfunction

    // Forward then back substitution in place; returns 1 on a zero diagonal.
    function automatic logic substitute();
        int n, k, c, m, bandn, last, lim, cr;
        n = reg_size == 0 ? 1 : (reg_size > 256 ? 256 : int'(reg_size));
        k = reg_band == 0 ? 1 : (reg_band > 16 ? 16 : int'(reg_band));
        m = reg_rhs == 0 ? 1 : (reg_rhs > 4 ? 4 : int'(reg_rhs));
        c = reg_corner;
        if (c > k) c = k;
        if (c > n) c = n;
        bandn = n - c;
        for (int i = 0; i < bandn; i++)
        begin
            clear_row_sums();
            for (int j = first_slot[i]; j < k - 1; j++)
                if (i + j - k + 1 >= 0) mac_column(band_coef[i][j], i + j - k + 1, m);
            if (band_coef[i][k-1] == 0) return 1'b1;
            divide_row(i, band_coef[i][k-1], m);
        end
        for (int i = bandn; i < n; i++)
        begin
            clear_row_sums();
            for (int j = 0; j < i; j++) mac_column(corner_coef[i-bandn][j], j, m);
            if (corner_coef[i-bandn][i] == 0) return 1'b1;
            divide_row(i, corner_coef[i-bandn][i], m);
        end
        last = n - 1;
        for (int i = n - 1; i >= 0; i--)
        begin
            if (last < i) last = i;
            // pull the reach back past rows whose band does not touch column i
            while (last > i && int'(first_slot[last]) >= k - last + i) last--;
            clear_row_sums();
            lim = i > bandn - 1 ? i : bandn - 1;
            cr = c - 1;
            for (int j = n - 1; j > lim; j--)
            begin
                mac_column(corner_coef[cr][i], j, m);
                cr--;
            end
            lim = last < bandn - 1 ? last : bandn - 1;
            for (int j = i + 1; j <= lim; j++) mac_column(band_coef[j][k-1-(j-i)], j, m);
            if (i >= bandn) divide_row(i, corner_coef[i-bandn][i], m);
            else divide_row(i, band_coef[i][k-1], m);
        end
        return 1'b0;
    endfunction

    // Apply one accepted item to the shadow and queue the outcome it must produce.
    task automatic predict_item(input logic [2:0] rq, input logic [7:0] r, input logic [7:0] cl,
                                input logic [1:0] cp, input logic [31:0] d);
        outcome_t o;
        o.st = 1'b0;
        o.val = '0;
        case (rq)
            bcs_pkg::REQ_BAND:   if (cl < 16) band_coef[r][cl] = longint'(signed'(d));
            bcs_pkg::REQ_CORNER: if (r < 16) corner_coef[r][cl] = longint'(signed'(d));
            bcs_pkg::REQ_RHS:    solution[r][cp] = longint'(signed'(d));
            bcs_pkg::REQ_START:  first_slot[r] = d[3:0];
            bcs_pkg::REQ_SOLVE:  o.st = substitute();
            bcs_pkg::REQ_READ:   o.val = solution[r][cp][31:0];
            default:             ;
        endcase
        awaited.push_back(o);
    endtask

    function automatic void write_register(logic [1:0] idx, logic [31:0] v);
        case (idx)
            bcs_pkg::REG_SYSTEM_SIZE: reg_size = v[8:0];
            bcs_pkg::REG_BAND_WIDTH:  reg_band = v[4:0];
            bcs_pkg::REG_CORNER_ROWS: reg_corner = v[4:0];
            bcs_pkg::REG_RHS_COUNT:   reg_rhs = v[2:0];
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int pick_gap();
        int g;
        if (!gapped) return 0;
        g = $urandom_range(0, 99);
        if (g < 70) return 0;
        if (g < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly moderate Q16.16 values so solves do not just saturate; some full range.
    function automatic logic [31:0] coef_value();
        if ($urandom_range(0, 3) != 0) return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        return $urandom;
    endfunction

    function automatic logic [31:0] pivot_value();
        logic [31:0] v;
        v = $urandom_range(1 << 15, 1 << 18);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    task automatic add_item(input logic [2:0] rq, input logic [7:0] r, input logic [7:0] cl,
                            input logic [1:0] cp, input logic [31:0] d);
        job_t j;
        j.is_cfg = 0;
        j.reg_idx = '0;
        j.wdata = '0;
        j.raw_req = rq;
        j.row = r;
        j.col = cl;
        j.comp = cp;
        j.data = d;
        j.gap = pick_gap();
        case (rq)
            bcs_pkg::REQ_BAND:   if (cl < 16) band_set[r][cl] = 1;
            bcs_pkg::REQ_CORNER: if (r < 16) corner_set[r][cl] = 1;
            bcs_pkg::REQ_RHS:    rhs_set[r][cp] = 1;
            bcs_pkg::REQ_START:  start_set[r] = 1;
            default:             ;
        endcase
        jobs.push_back(j);
    endtask

    task automatic add_config(input int sz, input int bw, input int cr, input int rc);
        job_t j;
        int vals[4];
        vals = '{sz, bw, cr, rc};
        j = '{default: 0};
        j.is_cfg = 1;
        for (int i = 0; i < 4; i++)
        begin
            j.reg_idx = 2'(i);
            j.wdata = vals[i];
            jobs.push_back(j);
        end
        g_n = (sz & 511) == 0 ? 1 : ((sz & 511) > 256 ? 256 : (sz & 511));
        g_k = (bw & 31) == 0 ? 1 : ((bw & 31) > 16 ? 16 : (bw & 31));
        g_m = (rc & 7) == 0 ? 1 : ((rc & 7) > 4 ? 4 : (rc & 7));
        g_c = cr & 31;
        if (g_c > g_k) g_c = g_k;
        if (g_c > g_n) g_c = g_n;
    endtask

    // Write every entry a solve under the current sizes reads and that is still unset.
    task automatic fill_missing();
        int bandn;
        bandn = g_n - g_c;
        for (int i = 0; i < g_n; i++)
        begin
            if (!start_set[i]) add_item(bcs_pkg::REQ_START, 8'(i), $urandom, $urandom, $urandom);
            for (int s = 0; s < g_k && i < bandn; s++)
                if (!band_set[i][s])
                    add_item(bcs_pkg::REQ_BAND, 8'(i), 8'(s), $urandom,
                             s == g_k - 1 ? pivot_value() : coef_value());
            for (int r = 0; r < g_m; r++)
                if (!rhs_set[i][r])
                    add_item(bcs_pkg::REQ_RHS, 8'(i), $urandom, 2'(r), coef_value());
        end
        for (int cr = 0; cr < g_c; cr++)
            for (int j = 0; j < g_n; j++)
                if (!corner_set[cr][j])
                    add_item(bcs_pkg::REQ_CORNER, 8'(cr), 8'(j), $urandom,
                             j == bandn + cr ? pivot_value() : coef_value());
    endtask

    // Well-formed traffic with random content; a few loads out of range and unknown codes.
    task automatic random_traffic(input int count, input int solve_weight);
        int sel;
        logic [31:0] d;
        for (int t = 0; t < count; t++)
        begin
            sel = $urandom_range(0, 99);
            d = ($urandom_range(0, 99) < 3) ? 32'd0 : coef_value();
            if (sel < 30)
                add_item(bcs_pkg::REQ_RHS, 8'($urandom_range(0, g_n - 1)), $urandom, $urandom,
                         coef_value());
            else if (sel < 42)
                add_item(bcs_pkg::REQ_BAND,
                         ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, g_n - 1)),
                         ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, g_k - 1)),
                         $urandom, d);
            else if (sel < 50)
                add_item(bcs_pkg::REQ_CORNER,
                         ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, g_c > 0 ? g_c - 1 : 0)),
                         8'($urandom_range(0, g_n - 1)), $urandom, d);
            else if (sel < 56)
                add_item(bcs_pkg::REQ_START, 8'($urandom_range(0, g_n - 1)), $urandom, $urandom,
                         $urandom);
            else if (sel < 56 + solve_weight)
                add_item(bcs_pkg::REQ_SOLVE, $urandom, $urandom, $urandom, $urandom);
            else if (sel < 97)
                add_item(bcs_pkg::REQ_READ, 8'($urandom_range(0, g_n - 1)), $urandom,
                         2'($urandom_range(0, g_m - 1)), $urandom);
            else
                add_item(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // ---------------------------------------------------------------- clock, driver, monitor

    initial
    begin
        forever #5 clk = ~clk;
    end

    int         idle_gap = 0;
    int         quiet_cycles = 0;
    logic [1:0] apb_step = 0;
    job_t       head;

    // Driver: hold start until accepted, insert gaps, and issue register writes
    // only once the block has drained every awaited result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            psel <= 0;
            penable <= 0;
            pwrite <= 0;
            apb_step <= 0;
            idle_gap <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (start && !busy) predict_item(req_type, row, column, component, data_value);
            quiet_cycles <= (awaited.size() == 0 && !start) ? quiet_cycles + 1 : 0;

            if (apb_step == 1)
            begin
                penable <= 1;
                apb_step <= 2;
            end
            else if (apb_step == 2)
            begin
                // the register takes the value at this edge
                write_register(paddr[3:2], pwdata);
                psel <= 0;
                penable <= 0;
                pwrite <= 0;
                apb_step <= 0;
            end

            if (start && busy)
                ; // hold the item
            else if (idle_gap > 0)
            begin
                start <= 0;
                idle_gap <= idle_gap - 1;
            end
            else if (apb_step == 0 && jobs.size() > 0 && !jobs[0].is_cfg)
            begin
                head = jobs.pop_front();
                req_type <= head.raw_req;
                row <= head.row;
                column <= head.col;
                component <= head.comp;
                data_value <= head.data;
                start <= 1;
                idle_gap <= head.gap;
            end
            else
            begin
                start <= 0;
                if (apb_step == 0 && jobs.size() > 0 && quiet_cycles >= 8)
                begin
                    head = jobs.pop_front();
                    psel <= 1;
                    pwrite <= 1;
                    paddr <= {head.reg_idx, 2'b00};
                    pwdata <= head.wdata;
                    apb_step <= 1;
                end
            end
        end
    end

    // Monitor: every strobe must match the oldest awaited outcome.
    always @(posedge clk)
    begin
        outcome_t o;
        if (rst_n && done)
        begin
            if (awaited.size() == 0)
                report("unexpected result", {31'd0, status}, 32'd0);
            else
            begin
                o = awaited.pop_front();
                if (status !== o.st) report("status", {31'd0, status}, {31'd0, o.st});
                if (read_value !== o.val) report("read_value", read_value, o.val);
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- test sequence

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            first_slot[i] = 0;
            start_set[i] = 0;
            for (int j = 0; j < 16; j++)
            begin
                band_coef[i][j] = 0;
                band_set[i][j] = 0;
                corner_coef[j][i] = 0;
                corner_set[j][i] = 0;
            end
            for (int r = 0; r < 4; r++)
            begin
                solution[i][r] = 0;
                rhs_set[i][r] = 0;
            end
        end

        // Directed: small system with corner rows and two right-hand sides.
        gapped = 1;
        add_config(5, 3, 2, 2);
        fill_missing();
        add_item(bcs_pkg::REQ_RHS, 8'd0, 8'd0, 2'd0, 32'h7FFF_FFFF);
        add_item(bcs_pkg::REQ_READ, 8'd0, 8'd0, 2'd0, 32'd0);
        add_item(bcs_pkg::REQ_RHS, 8'd1, 8'hFF, 2'd1, 32'h8000_0000);
        add_item(bcs_pkg::REQ_READ, 8'd1, 8'hFF, 2'd1, 32'hFFFF_FFFF);
        add_item(bcs_pkg::REQ_RHS, 8'd255, 8'd0, 2'd3, 32'h0001_0000);
        add_item(bcs_pkg::REQ_READ, 8'd255, 8'd0, 2'd3, 32'd0);
        // slot out of range, dropped
        add_item(bcs_pkg::REQ_BAND, 8'd0, 8'd16, 2'd0, 32'h1234_5678);
        add_item(bcs_pkg::REQ_BAND, 8'd255, 8'd255, 2'd3, 32'hFFFF_FFFF);
        // corner row out of range
        add_item(bcs_pkg::REQ_CORNER, 8'd16, 8'd0, 2'd0, 32'h0000_0001);
        add_item(bcs_pkg::REQ_CORNER, 8'd255, 8'd255, 2'd0, 32'h0000_0001);
        // only the low nibble counts
        add_item(bcs_pkg::REQ_START, 8'd255, 8'd0, 2'd0, 32'hFFFF_FFF3);
        add_item(3'd6, 8'hFF, 8'hFF, 2'd3, 32'hFFFF_FFFF);
        add_item(3'd7, 8'h00, 8'h00, 2'd0, 32'h0000_0000);
        add_item(bcs_pkg::REQ_SOLVE, 8'd0, 8'd0, 2'd0, 32'd0);
        for (int i = 0; i < 5; i++) add_item(bcs_pkg::REQ_READ, 8'(i), 8'd0, 2'd1, 32'd0);
        // zero pivot in the first band row: solve aborts with status set
        add_item(bcs_pkg::REQ_BAND, 8'd0, 8'd2, 2'd0, 32'd0);
        add_item(bcs_pkg::REQ_SOLVE, 8'd0, 8'd0, 2'd0, 32'd0);
        add_item(bcs_pkg::REQ_READ, 8'd0, 8'd0, 2'd0, 32'd0);
        // tiny pivot saturates
        add_item(bcs_pkg::REQ_BAND, 8'd0, 8'd2, 2'd0, 32'h0000_0001);
        add_item(bcs_pkg::REQ_SOLVE, 8'd0, 8'd0, 2'd0, 32'd0);
        add_item(bcs_pkg::REQ_READ, 8'd0, 8'd0, 2'd1, 32'd0);
        random_traffic(80, 10);

        // Smallest system, back to back.
        gapped = 0;
        add_config(1, 1, 0, 1);
        fill_missing();
        random_traffic(60, 12);

        // Zero and oversized register values that clamp.
        gapped = 1;
        add_config(0, 0, 31, 0);
        fill_missing();
        random_traffic(50, 12);

        // Widest band, all rows dense corner, four right-hand sides.
        add_config(16, 16, 16, 4);
        fill_missing();
        random_traffic(80, 6);

        add_config(20, 6, 3, 3);
        fill_missing();
        random_traffic(100, 6);

        // Right-hand side count clamps from 7 down to the maximum.
        add_config(8, 4, 4, 7);
        fill_missing();
        random_traffic(100, 8);

        repeat (10) @(posedge clk);
        rst_n <= 1;

        while (jobs.size() != 0 || start || apb_step != 0 || awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (awaited.size() != 0) report("results never arrived", awaited.size(), 32'd0);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/bcs_pkg.sv
sv/bcs_ram.sv
sv/bcs_div.sv
sv/bcs_datapath.sv
sv/bcs_ctrl.sv
sv/banded_cholesky_solve.sv
test/testbench.sv
